FILE: hw/rtl/dgsp_pkg.sv
// Shared types and constants for the dense-graph shortest path engine.
`default_nettype none

package dgsp_pkg;

  // Request command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  // Fixed field widths
  localparam int NODE_COUNT_BITS = 5;
  localparam int PORT_NODE_BITS  = 4;
  localparam int PORT_WT_BITS    = 8;
  localparam int DIST_BITS       = 13;
  localparam int OUT_DIST_BITS   = 12;

  // Distance codes: all ones means unreachable, sums saturate at 4095
  localparam logic [DIST_BITS-1:0]       DIST_NONE = 13'h1FFF;
  localparam logic [OUT_DIST_BITS-1:0]   DIST_MAX  = 12'hFFF;
  localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 5'd12;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_PICK,
    ST_RELAX,
    ST_RELAX_WAIT,
    ST_OUT_READ,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;    // clear one weight entry after reset
    logic wr_edge;     // store the edge of the accepted request
    logic run_start;   // latch node count and source, clear settled marks
    logic init_wr;     // write initial distance/parent at k
    logic scan_rd;     // read distance at k for the minimum scan
    logic best_reset;  // restart the minimum search
    logic settle;      // mark the picked node settled
    logic relax_rd;    // read weight and distance at k for relaxation
    logic out_load;    // load the result register from the read data
    logic out_take;    // result taken by the sink
    logic k_inc;
    logic k_reset;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic k_last;
    logic found;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dgsp_ctrl.sv
// Sequencing state machine for the shortest path engine.
`default_nettype none

module dgsp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_command,
  input  logic                   out_stall,
  input  dgsp_pkg::dp_status_t   status,
  output dgsp_pkg::ctrl_cmd_t    cmd,
  output logic                   in_stall
);

  dgsp_pkg::state_t state;
  dgsp_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgsp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dgsp_pkg::ST_CLEAR: begin
        if (status.clr_done) state_next = dgsp_pkg::ST_IDLE;
      end
      dgsp_pkg::ST_IDLE: begin
        if (in_valid && in_command == dgsp_pkg::CMD_RUN) state_next = dgsp_pkg::ST_INIT;
      end
      dgsp_pkg::ST_INIT: begin
        if (status.k_last) state_next = dgsp_pkg::ST_SCAN;
      end
      dgsp_pkg::ST_SCAN: begin
        if (status.k_last) state_next = dgsp_pkg::ST_SCAN_WAIT;
      end
      dgsp_pkg::ST_SCAN_WAIT: begin
        state_next = dgsp_pkg::ST_PICK;
      end
      dgsp_pkg::ST_PICK: begin
        state_next = status.found ? dgsp_pkg::ST_RELAX : dgsp_pkg::ST_OUT_READ;
      end
      dgsp_pkg::ST_RELAX: begin
        if (status.k_last) state_next = dgsp_pkg::ST_RELAX_WAIT;
      end
      dgsp_pkg::ST_RELAX_WAIT: begin
        state_next = dgsp_pkg::ST_SCAN;
      end
      dgsp_pkg::ST_OUT_READ: begin
        state_next = dgsp_pkg::ST_OUT_LOAD;
      end
      dgsp_pkg::ST_OUT_LOAD: begin
        state_next = dgsp_pkg::ST_OUT_WAIT;
      end
      dgsp_pkg::ST_OUT_WAIT: begin
        if (!out_stall) begin
          state_next = status.k_last ? dgsp_pkg::ST_IDLE : dgsp_pkg::ST_OUT_READ;
        end
      end
      default: begin
        state_next = dgsp_pkg::ST_CLEAR;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      dgsp_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      dgsp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_command == dgsp_pkg::CMD_RUN) begin
            cmd.run_start = 1'b1;
            cmd.k_reset   = 1'b1;
          end else begin
            cmd.wr_edge = 1'b1;
          end
        end
      end
      dgsp_pkg::ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.k_last) begin
          cmd.k_reset    = 1'b1;
          cmd.best_reset = 1'b1;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      dgsp_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.k_last) cmd.k_reset = 1'b1;
        else               cmd.k_inc   = 1'b1;
      end
      dgsp_pkg::ST_SCAN_WAIT: begin
        // last scan compare in flight
      end
      dgsp_pkg::ST_PICK: begin
        cmd.settle = status.found;
      end
      dgsp_pkg::ST_RELAX: begin
        cmd.relax_rd = 1'b1;
        if (status.k_last) cmd.k_reset = 1'b1;
        else               cmd.k_inc   = 1'b1;
      end
      dgsp_pkg::ST_RELAX_WAIT: begin
        cmd.best_reset = 1'b1;
      end
      dgsp_pkg::ST_OUT_READ: begin
        // distance read issued at k
      end
      dgsp_pkg::ST_OUT_LOAD: begin
        cmd.out_load = 1'b1;
      end
      dgsp_pkg::ST_OUT_WAIT: begin
        if (!out_stall) begin
          cmd.out_take = 1'b1;
          if (status.k_last) cmd.k_reset = 1'b1;
          else               cmd.k_inc   = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dgsp_datapath.sv
// Weight matrix, distance/parent store, minimum scan and relaxation unit.
`default_nettype none

module dgsp_datapath #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  dgsp_pkg::ctrl_cmd_t                        cmd,
  output dgsp_pkg::dp_status_t                       status,
  input  logic                                       cfg_write_en,
  input  logic [dgsp_pkg::NODE_COUNT_BITS-1:0]       cfg_write_data,
  input  logic [dgsp_pkg::PORT_NODE_BITS-1:0]        from_node,
  input  logic [dgsp_pkg::PORT_NODE_BITS-1:0]        to_node,
  input  logic [dgsp_pkg::PORT_WT_BITS-1:0]          edge_weight,
  input  logic                                       edge_present,
  input  logic [dgsp_pkg::PORT_NODE_BITS-1:0]        source,
  output logic                                       out_valid,
  output logic [dgsp_pkg::PORT_NODE_BITS-1:0]        node,
  output logic [dgsp_pkg::OUT_DIST_BITS-1:0]         distance,
  output logic                                       reachable,
  output logic [dgsp_pkg::PORT_NODE_BITS-1:0]        parent,
  output logic                                       last
);

  localparam int NB    = $clog2(MAX_NODES);
  localparam int CELLS = MAX_NODES * MAX_NODES;
  localparam int WA    = $clog2(CELLS);
  localparam int WW    = WEIGHT_BITS + 1;
  localparam int SW    = ((WEIGHT_BITS > dgsp_pkg::OUT_DIST_BITS) ?
                          WEIGHT_BITS : dgsp_pkg::OUT_DIST_BITS) + 1;
  localparam int DB    = dgsp_pkg::DIST_BITS;
  localparam int PB    = dgsp_pkg::PORT_NODE_BITS;
  localparam logic [WA-1:0] ROW       = WA'(MAX_NODES);
  localparam logic [WA-1:0] LAST_CELL = WA'(CELLS - 1);
  localparam logic [NB-1:0] NODE_LAST = NB'(MAX_NODES - 1);

  // Node count register
  logic [dgsp_pkg::NODE_COUNT_BITS-1:0] node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dgsp_pkg::NODE_COUNT_RESET;
    end else if (cfg_write_en) begin
      node_count <= cfg_write_data;
    end
  end

  // Run bounds: zero acts as one, large counts saturate
  logic [NB-1:0] n_last_next;
  logic          src_ok_next;

  always_comb begin
    priority if (node_count == '0) begin
      n_last_next = '0;
    end else if ({27'd0, node_count} > 32'(MAX_NODES)) begin
      n_last_next = NODE_LAST;
    end else begin
      n_last_next = NB'(node_count - 5'd1);
    end
    src_ok_next = ({28'd0, source} <= 32'(n_last_next));
  end

  // Run registers
  logic [NB-1:0]        n_last;
  logic                 src_ok;
  logic [NB-1:0]        src_idx;
  logic [NB-1:0]        k;
  logic [WA-1:0]        clr_cnt;
  logic [MAX_NODES-1:0] settled;
  logic                 scan_vld;
  logic                 relax_vld;
  logic [NB-1:0]        scan_k;
  logic [NB-1:0]        relax_k;
  logic [DB-1:0]        best;
  logic                 found;
  logic [NB-1:0]        pick;

  // Weight matrix: present bit over weight
  logic [WW-1:0]          wmem [CELLS];
  logic [WW-1:0]          w_rd;
  logic                   wm_we;
  logic [WA-1:0]          wm_waddr;
  logic [WW-1:0]          wm_wdata;
  logic [WA-1:0]          wm_raddr;
  logic [WA-1:0]          edge_addr;
  logic                   edge_ok;
  logic [WEIGHT_BITS-1:0] w_in;

  assign w_in      = WEIGHT_BITS'(edge_weight);
  assign edge_ok   = ({28'd0, from_node} < 32'(MAX_NODES)) &&
                     ({28'd0, to_node} < 32'(MAX_NODES));
  assign edge_addr = WA'(NB'(from_node)) * ROW + WA'(NB'(to_node));
  assign wm_raddr  = WA'(pick) * ROW + WA'(k);

  always_comb begin
    wm_we    = 1'b0;
    wm_waddr = clr_cnt;
    wm_wdata = '0;
    priority if (cmd.clr_step) begin
      wm_we = 1'b1;
    end else if (cmd.wr_edge && edge_ok) begin
      wm_we    = 1'b1;
      wm_waddr = edge_addr;
      wm_wdata = edge_present ? {1'b1, w_in} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[wm_waddr] <= wm_wdata;
    end
    w_rd <= wmem[wm_raddr];
  end

  // Distance and parent store
  logic [DB-1:0] dist_mem [MAX_NODES];
  logic [NB-1:0] par_mem  [MAX_NODES];
  logic [DB-1:0] dist_rd;
  logic [NB-1:0] par_rd;
  logic          dm_we;
  logic [NB-1:0] dm_waddr;
  logic [DB-1:0] dm_wdist;
  logic [NB-1:0] dm_wpar;

  // Relaxation: saturating add and strict improvement test
  logic [SW-1:0]                      sum_full;
  logic [dgsp_pkg::OUT_DIST_BITS-1:0] sum_sat;
  logic                               improve;
  logic                               init_src;

  assign sum_full = SW'(best[dgsp_pkg::OUT_DIST_BITS-1:0]) + SW'(w_rd[WEIGHT_BITS-1:0]);
  assign sum_sat  = (sum_full > SW'(dgsp_pkg::DIST_MAX)) ? dgsp_pkg::DIST_MAX
                                                         : sum_full[dgsp_pkg::OUT_DIST_BITS-1:0];
  assign improve  = relax_vld && w_rd[WW-1] && ({1'b0, sum_sat} < dist_rd);
  assign init_src = src_ok && (k == src_idx);

  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = k;
    dm_wdist = dgsp_pkg::DIST_NONE;
    dm_wpar  = '0;
    priority if (cmd.init_wr) begin
      dm_we    = 1'b1;
      dm_wdist = init_src ? '0 : dgsp_pkg::DIST_NONE;
      dm_wpar  = init_src ? src_idx : '0;
    end else if (improve) begin
      dm_we    = 1'b1;
      dm_waddr = relax_k;
      dm_wdist = {1'b0, sum_sat};
      dm_wpar  = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dist_mem[dm_waddr] <= dm_wdist;
      par_mem[dm_waddr]  <= dm_wpar;
    end
    dist_rd <= dist_mem[k];
    par_rd  <= par_mem[k];
  end

  // Minimum scan compare
  logic scan_hit;
  assign scan_hit = scan_vld && !settled[scan_k] && (dist_rd < best);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      k         <= '0;
      n_last    <= '0;
      src_ok    <= 1'b0;
      settled   <= '0;
      scan_vld  <= 1'b0;
      relax_vld <= 1'b0;
      best      <= dgsp_pkg::DIST_NONE;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.k_reset)    k <= '0;
      else if (cmd.k_inc) k <= k + 1'b1;
      scan_vld  <= cmd.scan_rd;
      relax_vld <= cmd.relax_rd;
      if (cmd.run_start) begin
        n_last  <= n_last_next;
        src_ok  <= src_ok_next;
        settled <= '0;
      end else if (cmd.settle) begin
        settled[pick] <= 1'b1;
      end
      if (cmd.best_reset) begin
        best  <= dgsp_pkg::DIST_NONE;
        found <= 1'b0;
      end else if (scan_hit) begin
        best  <= dist_rd;
        found <= 1'b1;
      end
      if (cmd.out_load)      out_valid <= 1'b1;
      else if (cmd.out_take) out_valid <= 1'b0;
    end
  end

  // Payload registers
  logic reach_rd;
  assign reach_rd = (dist_rd != dgsp_pkg::DIST_NONE);

  always_ff @(posedge clk) begin
    scan_k  <= k;
    relax_k <= k;
    if (cmd.run_start) src_idx <= NB'(source);
    if (scan_hit)      pick    <= scan_k;
    if (cmd.out_load) begin
      node      <= PB'(k);
      distance  <= reach_rd ? dist_rd[dgsp_pkg::OUT_DIST_BITS-1:0] : '0;
      reachable <= reach_rd;
      parent    <= reach_rd ? PB'(par_rd) : '0;
      last      <= (k == n_last);
    end
  end

  assign status.clr_done = (clr_cnt == LAST_CELL);
  assign status.k_last   = (k == n_last);
  assign status.found    = found;

endmodule

`default_nettype wire

FILE: hw/rtl/dense_graph_shortest_path.sv
// Top level of the dense-graph single-source shortest path engine.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | command from_node to_node edge_weight
//          |                      | edge_present source
//  out     | out_valid / out_stall| node distance reachable parent last
//  cfg     | cfg_write_en         | cfg_write_data (node_count)
//
// After reset the weight matrix is cleared one entry a cycle, with in_stall high.
// An edge write is stored as it is accepted, and the input stays open. A run of
// n nodes writes the initial distances, then for each settled node scans for
// the unsettled minimum and relaxes the picked row (minimum scan and row
// relaxation each visit one node a cycle), then sends one result per node,
// each held while out_stall is high. One request is in work at a time;
// in_stall stays high until the last result of a run is taken.
`default_nettype none

module dense_graph_shortest_path #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  from_node,
  input  logic [3:0]  to_node,
  input  logic [7:0]  edge_weight,
  input  logic        edge_present,
  input  logic [3:0]  source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  node,
  output logic [11:0] distance,
  output logic        reachable,
  output logic [3:0]  parent,
  output logic        last
);

  dgsp_pkg::ctrl_cmd_t  cmd;
  dgsp_pkg::dp_status_t status;

  dgsp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (command),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd),
    .in_stall   (in_stall)
  );

  dgsp_datapath #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .from_node      (from_node),
    .to_node        (to_node),
    .edge_weight    (edge_weight),
    .edge_present   (edge_present),
    .source         (source),
    .out_valid      (out_valid),
    .node           (node),
    .distance       (distance),
    .reachable      (reachable),
    .parent         (parent),
    .last           (last)
  );

  // No new request while a result is pending
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

  // A result load always shows up on the output
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

  // A run request closes the input side
  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == dgsp_pkg::CMD_RUN) |=> in_stall)
    else $error("input open right after a run request");

  // Only a found minimum gets settled
  a_settle_found: assert property (@(posedge clk) disable iff (rst)
    cmd.settle |-> status.found)
    else $error("settle without a found node");

endmodule

`default_nettype wire

FILE: tb/dgsp_path_checker.sv
// Shortest path checker: predicts every node result of a run and compares it with the engine's output.
`default_nettype none

module dgsp_path_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_write_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [3:0]  from_node,
  input  logic [3:0]  to_node,
  input  logic [7:0]  edge_weight,
  input  logic        edge_present,
  input  logic [3:0]  source,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  node,
  input  logic [11:0] distance,
  input  logic        reachable,
  input  logic [3:0]  parent,
  input  logic        last,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]                         node;
    logic [dgsp_pkg::OUT_DIST_BITS-1:0] distance;
    logic                               reachable;
    logic [3:0]                         parent;
    logic                               last;
  } path_result_t;

  // Mirror of the engine: present bit over weight, indexed {from, to}
  logic [8:0]                           edge_table [256];
  logic [dgsp_pkg::NODE_COUNT_BITS-1:0] node_limit;
  path_result_t                         expected_paths [$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // Dijkstra over the mirrored matrix; queues one result per node in use
  function automatic void predict_run(input logic [3:0] src);
    logic [dgsp_pkg::DIST_BITS-1:0] path_len [16];
    logic                           done [16];
    logic [3:0]                     prev [16];
    logic [dgsp_pkg::DIST_BITS-1:0] best;
    logic [dgsp_pkg::DIST_BITS-1:0] sum;
    logic [8:0]                     entry;
    int                             span;
    int                             pick;
    bit                             found;
    path_result_t                   res;
    span = (node_limit == 0) ? 1 : ((node_limit > 16) ? 16 : int'(node_limit));
    for (int i = 0; i < 16; i++) begin
      path_len[i] = dgsp_pkg::DIST_NONE;
      done[i]     = 1'b0;
      prev[i]     = '0;
    end
    if (int'(src) < span) begin
      path_len[src] = '0;
      prev[src]     = src;
      found = 1'b1;
      while (found) begin
        // lowest unsettled distance, lowest index on ties
        found = 1'b0;
        best  = dgsp_pkg::DIST_NONE;
        pick  = 0;
        for (int k = 0; k < span; k++) begin
          if (!done[k] && path_len[k] < best) begin
            best  = path_len[k];
            pick  = k;
            found = 1'b1;
          end
        end
        if (found) begin
          done[pick] = 1'b1;
          // relax the picked row, strict improvement only
          for (int k = 0; k < span; k++) begin
            entry = edge_table[pick * 16 + k];
            if (entry[8]) begin
              sum = best + {5'd0, entry[7:0]};
              if (sum > {1'b0, dgsp_pkg::DIST_MAX}) sum = {1'b0, dgsp_pkg::DIST_MAX};
              if (sum < path_len[k]) begin
                path_len[k] = sum;
                prev[k]     = pick[3:0];
              end
            end
          end
        end
      end
    end
    for (int i = 0; i < span; i++) begin
      res.node      = i[3:0];
      res.reachable = (path_len[i] != dgsp_pkg::DIST_NONE);
      res.distance  = res.reachable ? path_len[i][dgsp_pkg::OUT_DIST_BITS-1:0] : '0;
      res.parent    = res.reachable ? prev[i] : '0;
      res.last      = (i == span - 1);
      expected_paths.push_back(res);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    path_result_t want;
    if (rst) begin
      for (int i = 0; i < 256; i++) edge_table[i] = '0;
      node_limit = dgsp_pkg::NODE_COUNT_RESET;
      expected_paths.delete();
    end else begin
      if (cfg_write_en) node_limit = cfg_write_data;
      // accepted request: edge load or search
      if (in_valid && !in_stall) begin
        if (command == dgsp_pkg::CMD_WRITE)
          edge_table[{from_node, to_node}] = {edge_present, edge_present ? edge_weight : 8'd0};
        else
          predict_run(source);
      end
      // accepted result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_paths.size() == 0) begin
          $error("unexpected result for node %0d", node);
          fail_count++;
        end else begin
          want = expected_paths.pop_front();
          check_field("node", 32'(want.node), 32'(node));
          check_field("distance", 32'(want.distance), 32'(distance));
          check_field("reachable", 32'(want.reachable), 32'(reachable));
          check_field("parent", 32'(want.parent), 32'(parent));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
    end
    pending <= expected_paths.size();
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Top of the shortest path testbench: clock, reset, request and stall stimulus, verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [4:0]  cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = dgsp_pkg::CMD_WRITE;
  logic [3:0]  from_node = '0;
  logic [3:0]  to_node = '0;
  logic [7:0]  edge_weight = '0;
  logic        edge_present = 1'b0;
  logic [3:0]  source = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  node;
  logic [11:0] distance;
  logic        reachable;
  logic [3:0]  parent;
  logic        last;
  int          pending;
  int          fail_count;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  always #5 clk = ~clk;

  dense_graph_shortest_path u_dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .from_node(from_node), .to_node(to_node),
    .edge_weight(edge_weight), .edge_present(edge_present), .source(source),
    .out_valid(out_valid), .out_stall(out_stall),
    .node(node), .distance(distance), .reachable(reachable),
    .parent(parent), .last(last)
  );

  dgsp_path_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .from_node(from_node), .to_node(to_node),
    .edge_weight(edge_weight), .edge_present(edge_present), .source(source),
    .out_valid(out_valid), .out_stall(out_stall),
    .node(node), .distance(distance), .reachable(reachable),
    .parent(parent), .last(last),
    .pending(pending), .fail_count(fail_count)
  );

  // One request: optional gap, then hold until accepted
  task automatic send_request(input logic cmd, input logic [3:0] from_n, input logic [3:0] to_n,
                              input logic [7:0] wt, input logic pres, input logic [3:0] src);
    int gap;
    if ($urandom_range(0, 9) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    from_node    <= from_n;
    to_node      <= to_n;
    edge_weight  <= wt;
    edge_present <= pres;
    source       <= src;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Register write only with the engine idle
  task automatic set_node_count(input logic [4:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    while (in_stall) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Reset, held high from time zero, then released
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Result side: random stall before each result, with stall-free stretches
  initial begin : result_sink
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 11) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int span;
    logic [4:0] limit;
    logic [3:0] from_n;
    logic [3:0] to_n;
    logic [7:0] wt;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed: empty graph, out-of-range source, ties, zero and full weights
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd0);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd12);
    send_request(dgsp_pkg::CMD_WRITE, 4'd0, 4'd1, 8'd255, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd0, 4'd2, 8'd1, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd2, 4'd1, 8'd254, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd1, 4'd3, 8'd0, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd2, 4'd3, 8'd255, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd3, 4'd11, 8'd128, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd11, 4'd0, 8'd7, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd5, 4'd6, 8'd85, 1'b0, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd15, 4'd14, 8'd170, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd11, 4'd15, 8'd9, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_WRITE, 4'd4, 4'd4, 8'd3, 1'b1, 4'd0);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd0);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd11);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd15);
    set_node_count(5'd16);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd15);
    send_request(dgsp_pkg::CMD_WRITE, 4'd2, 4'd1, 8'd0, 1'b0, 4'd0);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd0);
    set_node_count(5'd0);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd0);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd5);
    set_node_count(5'd31);
    send_request(dgsp_pkg::CMD_RUN, 4'd0, 4'd0, 8'd0, 1'b0, 4'd14);

    // Random phases: one node count each, graph edits mostly inside the used nodes
    for (int phase = 0; phase < 6; phase++) begin
      unique case (phase)
        0: limit = 5'd16;
        1: limit = 5'd3;
        2: limit = 5'd1;
        3: limit = 5'd31;
        4: limit = 5'd9;
        default: limit = 5'($urandom_range(0, 31));
      endcase
      set_node_count(limit);
      span = (limit == 0) ? 1 : ((limit > 16) ? 16 : int'(limit));
      for (int item = 0; item < 25; item++) begin
        // mid-phase pause until all results are back
        if (phase == 3 && item == 12) drain_results();
        if ($urandom_range(0, 4) == 0) begin
          from_n = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, span - 1));
          send_request(dgsp_pkg::CMD_RUN, 4'($urandom), 4'($urandom), 8'($urandom),
                       1'($urandom), from_n);
        end else begin
          from_n = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, span - 1));
          to_n   = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, span - 1));
          // small weights make equal-cost paths likely
          wt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
          send_request(dgsp_pkg::CMD_WRITE, from_n, to_n, wt, ($urandom_range(0, 4) != 0),
                       4'($urandom));
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: dense_graph_shortest_path.f
hw/rtl/dgsp_pkg.sv
hw/rtl/dgsp_ctrl.sv
hw/rtl/dgsp_datapath.sv
hw/rtl/dense_graph_shortest_path.sv
tb/dgsp_path_checker.sv
tb/testbench.sv
